// ===== src/fdc_pkg.sv =====
// Shared types and constants for the Fenwick dominance counter.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package fdc_pkg;

    // Tree geometry: entries are indexed 1..TREE_SIZE, stored at index-1.
    localparam int TREE_SIZE = 65536;
    localparam int ADDR_W    = $clog2(TREE_SIZE);
    localparam int IDX_W     = $clog2(TREE_SIZE + 1);

    localparam int COORD_W = 16;
    localparam int COUNT_W = 16;
    localparam int ENTRY_W = 17;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QSTEP,
        ST_USTEP,
        ST_RESULT
    } state_t;

endpackage

// ===== src/fdc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module fdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fenwick_dominance_counter.sv =====
// Fenwick dominance counter: top level with sequencer, shared adder and tree RAM.
// Depends on fdc_pkg and fdc_ram.
// A count request runs one query step per set bit of its tree index, then one update
// step per update index (a repeated point skips the query), then loads the output
// once the output is free. The block takes one request at a time; in_stall stays
// high until the result is loaded. A clear request answers 0 and then sweeps the
// tree RAM, one entry a cycle. After reset the same sweep runs first.
`timescale 1ns / 1ps

module fenwick_dominance_counter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [fdc_pkg::COORD_W-1:0] point_x,
    input  logic [fdc_pkg::COORD_W-1:0] point_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fdc_pkg::COUNT_W-1:0] match_count
);

    import fdc_pkg::*;

    localparam int CMP_W = (IDX_W > COORD_W + 1) ? IDX_W : COORD_W + 1;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     item_idx_reg, item_idx_next;
    logic [COUNT_W-1:0]   sum_reg, sum_next;
    logic [COORD_W-1:0]   prev_x_reg, prev_x_next;
    logic [COORD_W-1:0]   prev_y_reg, prev_y_next;
    logic [COUNT_W-1:0]   prev_count_reg, prev_count_next;
    logic                 prev_valid_reg, prev_valid_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                 pend_clr_reg, pend_clr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   match_count_reg, match_count_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 in_accept;
    logic [CMP_W-1:0]     x_plus;
    logic [IDX_W-1:0]     in_idx;
    logic                 repeat_hit;
    logic [IDX_W-1:0]     low_bit;
    logic [IDX_W-1:0]     idx_down;
    logic [IDX_W:0]       idx_up;
    logic [COUNT_W+1:0]   sum_wide;
    logic                 out_free;

    fdc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TREE_SIZE)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign match_count = match_count_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // Tree index of the incoming point, held at the top of the tree.
    assign x_plus = CMP_W'(point_x) + CMP_W'(1);
    assign in_idx = (x_plus > CMP_W'(TREE_SIZE)) ? IDX_W'(TREE_SIZE)
                                                 : x_plus[IDX_W-1:0];
    assign repeat_hit = prev_valid_reg && (point_x == prev_x_reg)
                        && (point_y == prev_y_reg);

    assign low_bit  = idx_reg & (~idx_reg + IDX_W'(1));
    assign idx_down = idx_reg - low_bit;
    assign idx_up   = {1'b0, idx_reg} + {1'b0, low_bit};
    assign sum_wide = {2'b00, sum_reg} + {1'b0, ram_rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            pend_clr_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            pend_clr_reg   <= pend_clr_next;
            prev_valid_reg <= prev_valid_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_count_reg <= prev_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        item_idx_reg    <= item_idx_next;
        sum_reg         <= sum_next;
        match_count_reg <= match_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        item_idx_next    = item_idx_reg;
        sum_next         = sum_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        prev_count_next  = prev_count_reg;
        prev_valid_next  = prev_valid_reg;
        clr_addr_next    = clr_addr_reg;
        pend_clr_next    = pend_clr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        match_count_next = match_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(TREE_SIZE - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_CLEAR)
                    begin
                        sum_next        = '0;
                        prev_valid_next = 1'b0;
                        pend_clr_next   = 1'b1;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        // Both paths start by reading the entry at the point's index.
                        ram_raddr       = ADDR_W'(in_idx - IDX_W'(1));
                        idx_next        = in_idx;
                        item_idx_next   = in_idx;
                        prev_x_next     = point_x;
                        prev_y_next     = point_y;
                        prev_valid_next = 1'b1;
                        pend_clr_next   = 1'b0;
                        if (repeat_hit)
                        begin
                            sum_next   = prev_count_reg;
                            state_next = ST_USTEP;
                        end
                        else
                        begin
                            sum_next   = '0;
                            state_next = ST_QSTEP;
                        end
                    end
                end
            end

            ST_QSTEP:
            begin
                sum_next = (sum_wide > {2'b00, COUNT_MAX}) ? COUNT_MAX
                                                           : sum_wide[COUNT_W-1:0];
                if (idx_down == '0)
                begin
                    // Query done: restart from the point's index for the update.
                    ram_raddr  = ADDR_W'(item_idx_reg - IDX_W'(1));
                    idx_next   = item_idx_reg;
                    state_next = ST_USTEP;
                end
                else
                begin
                    ram_raddr = ADDR_W'(idx_down - IDX_W'(1));
                    idx_next  = idx_down;
                end
            end

            ST_USTEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(idx_reg - IDX_W'(1));
                ram_wdata = (ram_rdata == ENTRY_MAX) ? ENTRY_MAX
                                                     : ram_rdata + ENTRY_W'(1);
                if (idx_up > (IDX_W + 1)'(TREE_SIZE))
                begin
                    prev_count_next = sum_reg;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    ram_raddr = ADDR_W'(idx_up - (IDX_W + 1)'(1));
                    idx_next  = idx_up[IDX_W-1:0];
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    match_count_next = sum_reg;
                    state_next       = pend_clr_reg ? ST_CLEAR : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The tree is only read while the prefix sum runs.
    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QSTEP) |-> !ram_we)
        else $error("tree written during query");

    a_update_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_USTEP) |->
            (idx_reg != '0) && ({1'b0, idx_reg} <= (IDX_W + 1)'(TREE_SIZE)))
        else $error("update index out of tree range");

    a_clear_forgets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req_type == REQ_CLEAR)) |=>
            (state_reg == ST_RESULT) && !prev_valid_reg && (sum_reg == '0))
        else $error("clear request did not reset the previous point");

    a_clear_follows_reply: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && pend_clr_reg && out_free) |=>
            (state_reg == ST_CLEAR) && out_valid_reg && (match_count_reg == '0))
        else $error("clear reply or sweep missing");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for fenwick_dominance_counter: directed table, then sorted point sets.
// Predicts each count with its own Fenwick tree model unless a directed row gives it; depends on fdc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import fdc_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AT     = 400;
    localparam int IDLE_PCT    = 18;

    typedef struct packed {
        logic        rt;
        logic [15:0] x;
        logic [15:0] y;
        logic        typed;
        logic [15:0] want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_COUNT;
    logic [15:0] point_x = '0;
    logic [15:0] point_y = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] match_count;

    // Idling on both sides is switched off for one whole point set.
    logic        steady_phase = 1'b0;
    int          fail_count = 0;
    logic [15:0] count_expect_q[$];

    // Predicted tree, keyed by Fenwick index; a missing key is a zero entry.
    int unsigned fen_tree [int unsigned];
    logic [15:0] last_x = '0;
    logic [15:0] last_y = '0;
    logic [15:0] last_count = '0;
    logic        last_valid = 1'b0;

    dir_row_t dir_rows [0:19] = '{
        // After reset the zero point matches the reset history but is still queried.
        '{REQ_COUNT, 16'h0000, 16'h0000, 1'b1, 16'd0},
        '{REQ_COUNT, 16'h0000, 16'h0000, 1'b1, 16'd0},
        '{REQ_COUNT, 16'h0000, 16'h0000, 1'b1, 16'd0},
        '{REQ_COUNT, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0},
        '{REQ_COUNT, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0},
        '{REQ_COUNT, 16'h0000, 16'hFFFF, 1'b0, 16'd0},
        '{REQ_COUNT, 16'h8000, 16'h0064, 1'b0, 16'd0},
        '{REQ_COUNT, 16'hAAAA, 16'h5555, 1'b0, 16'd0},
        '{REQ_COUNT, 16'h5555, 16'hAAAA, 1'b0, 16'd0},
        '{REQ_COUNT, 16'h0001, 16'h0001, 1'b0, 16'd0},
        '{REQ_COUNT, 16'h8000, 16'hFFFF, 1'b0, 16'd0},
        '{REQ_COUNT, 16'h7FFF, 16'h0000, 1'b0, 16'd0},
        '{REQ_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0},
        // The point before the clear must be forgotten, so this is a fresh query.
        '{REQ_COUNT, 16'h7FFF, 16'h0000, 1'b1, 16'd0},
        '{REQ_COUNT, 16'h7FFF, 16'h0000, 1'b1, 16'd0},
        '{REQ_COUNT, 16'hFFFF, 16'h0000, 1'b0, 16'd0},
        '{REQ_CLEAR, 16'h0000, 16'h0000, 1'b1, 16'd0},
        '{REQ_CLEAR, 16'hAAAA, 16'h5555, 1'b1, 16'd0},
        '{REQ_COUNT, 16'hFFFF, 16'h0000, 1'b1, 16'd0},
        '{REQ_COUNT, 16'h0000, 16'hFFFF, 1'b0, 16'd0}
    };

    fenwick_dominance_counter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_count (match_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] predict_dominance(input logic rt, input logic [15:0] x,
                                                      input logic [15:0] y);
        int unsigned node;
        int unsigned i;
        longint unsigned total;
        logic [15:0] answer;
        if (rt == REQ_CLEAR)
        begin
            fen_tree.delete();
            last_valid = 1'b0;
            return '0;
        end
        node = int'(x) + 1;
        if (node > TREE_SIZE)
            node = TREE_SIZE;
        if (last_valid && x == last_x && y == last_y)
            answer = last_count;
        else
        begin
            total = 0;
            for (i = node; i > 0; i -= i & (~i + 1))
                if (fen_tree.exists(i))
                    total += fen_tree[i];
            answer = (total > COUNT_MAX) ? COUNT_MAX : total[15:0];
        end
        for (i = node; i >= 1 && i <= TREE_SIZE; i += i & (~i + 1))
        begin
            if (!fen_tree.exists(i))
                fen_tree[i] = 1;
            else if (fen_tree[i] < ENTRY_MAX)
                fen_tree[i] = fen_tree[i] + 1;
        end
        last_x     = x;
        last_y     = y;
        last_count = answer;
        last_valid = 1'b1;
        return answer;
    endfunction

    // Offers one request, holds it until accepted, then records what it should answer.
    task automatic issue_request(input logic rt, input logic [15:0] x, input logic [15:0] y,
                                 input logic typed, input logic [15:0] want);
        logic [15:0] predicted;
        if (!steady_phase && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        point_x  <= x;
        point_y  <= y;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_dominance(rt, x, y);
        count_expect_q.push_back(typed ? want : predicted);
    endtask

    task automatic drain_counts();
        in_valid <= 1'b0;
        while (count_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: checks each count in order and applies back-pressure.
    initial
    begin
        int hold_left;
        int results_seen;
        logic [15:0] want;
        hold_left    = 0;
        results_seen = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (count_expect_q.size() == 0)
                begin
                    $error("match_count: no request pending, actual %0d", match_count);
                    fail_count++;
                end
                else
                begin
                    want = count_expect_q.pop_front();
                    if (match_count !== want)
                    begin
                        $error("match_count mismatch: expected %0d, actual %0d",
                               want, match_count);
                        fail_count++;
                    end
                end
                // One long hold so that the block backs up into its input.
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !steady_phase && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int set_no;
        int k;
        int r;
        int set_len;
        int span;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] cur_x;
        logic [15:0] cur_y;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue_request(dir_rows[i].rt, dir_rows[i].x, dir_rows[i].y,
                          dir_rows[i].typed, dir_rows[i].want);

        // Each set is mostly points in sorted order (y descending, x ascending),
        // with exact repeats and some unsorted points mixed in.
        for (set_no = 0; set_no < 5; set_no++)
        begin
            steady_phase <= (set_no == 2);
            if (set_no > 0)
                issue_request(REQ_CLEAR, 16'($urandom), 16'($urandom), 1'b1, 16'd0);
            cur_x   = 16'($urandom);
            cur_y   = 16'($urandom);
            set_len = 210 + $urandom_range(30);
            for (k = 0; k < set_len; k++)
            begin
                r = $urandom_range(99);
                if (r < 12)
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                else
                begin
                    if (r < 24)
                        ;
                    else if (r < 60 && cur_x != 16'hFFFF)
                    begin
                        span  = 65535 - int'(cur_x);
                        cur_x = cur_x + 16'($urandom_range(1, span < 3000 ? span : 3000));
                    end
                    else
                    begin
                        if (cur_y == 16'h0000)
                            cur_y = 16'hFFFF;
                        else
                            cur_y = cur_y - 16'($urandom_range(1, cur_y < 500 ? cur_y : 500));
                        cur_x = 16'($urandom);
                    end
                    px = cur_x;
                    py = cur_y;
                end
                issue_request(REQ_COUNT, px, py, 1'b0, 16'd0);
                if (set_no == 3 && k == 100)
                    drain_counts();
            end
        end

        drain_counts();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
